// File: rtl/oat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table: shared definitions
// Command and response word layouts, operation codes and status codes.
// ----------------------------------------------------------------------------
package oat_pkg;

    // Field widths of the command and response words.
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int RIDX_W   = 4;
    localparam int FILL_W   = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ELEMENT  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_value;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [RIDX_W-1:0]        result_index;
        logic signed [DATA_W-1:0] result_value;
        logic [FILL_W-1:0]        fill_level;
        logic                     last;
    } rsp_word_t;

endpackage

// File: rtl/oat_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table: stream channel
// Valid/ready channel carrying one word of a given type per handshake.
// ----------------------------------------------------------------------------
interface oat_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: rtl/oat_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table: entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oat_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem_array [DEPTH];
    logic [31:0] rd_data_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/oat_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table: command sequencer
// Decodes a command, walks the entry memory one entry per unstalled cycle
// (shift, search or read out) and loads results into a one-word output slot.
// ----------------------------------------------------------------------------
module oat_seq #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    oat_stream_if.sink    cmd,
    oat_stream_if.source  rsp,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [31:0]   mem_wr_data,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  logic [31:0]   mem_rd_data
);

    import oat_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FINISH,
        S_REPLY
    } state_t;

    state_t             state_reg,       state_next;
    logic [OP_W-1:0]    op_reg,          op_next;
    logic [POS_W-1:0]   pos_reg,         pos_next;
    logic [31:0]        val_reg,         val_next;
    logic [CW-1:0]      count_reg,       count_next;
    logic [AW-1:0]      issue_idx_reg,   issue_idx_next;
    logic [CW-1:0]      issue_left_reg,  issue_left_next;
    logic               rd_pend_reg,     rd_pend_next;
    logic [AW-1:0]      rd_idx_reg,      rd_idx_next;
    logic               pend_valid_reg,  pend_valid_next;
    logic [AW-1:0]      pend_idx_reg,    pend_idx_next;
    logic [31:0]        pend_val_reg,    pend_val_next;
    logic [STATUS_W-1:0] rep_status_reg, rep_status_next;
    logic               out_valid_reg,   out_valid_next;
    rsp_word_t          out_word_reg,    out_word_next;

    logic      can_emit;
    logic      need_emit;
    logic      stall;
    logic      emit;
    rsp_word_t emit_word;
    logic      is_match;

    assign can_emit  = !out_valid_reg || rsp.ready;
    assign is_match  = (mem_rd_data == val_reg);
    assign need_emit = rd_pend_reg && ((op_reg == OP_READ) ||
                       ((op_reg == OP_SEARCH) && is_match && pend_valid_reg));
    assign stall     = need_emit && !can_emit;

    // Next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        issue_idx_next  = issue_idx_reg;
        issue_left_next = issue_left_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_val_next   = pend_val_reg;
        rep_status_next = rep_status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = issue_idx_reg;
        emit            = 1'b0;
        emit_word       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.payload.operation;
                    pos_next   = cmd.payload.position;
                    val_next   = cmd.payload.data_value;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                pend_valid_next = 1'b0;
                rd_pend_next    = 1'b0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            rep_status_next = ST_FULL;
                            state_next      = S_REPLY;
                        end
                        else if ((32'(pos_reg) >= 32'(CAPACITY)) ||
                                 (32'(pos_reg) > 32'(count_reg)))
                        begin
                            rep_status_next = ST_BADIDX;
                            state_next      = S_REPLY;
                        end
                        else
                        begin
                            // Move entries from the top down to the target.
                            issue_idx_next  = AW'(count_reg - CW'(1));
                            issue_left_next = count_reg - CW'(pos_reg);
                            state_next      = S_SCAN;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            rep_status_next = ST_EMPTY;
                            state_next      = S_REPLY;
                        end
                        else if (32'(pos_reg) >= 32'(count_reg))
                        begin
                            rep_status_next = ST_BADIDX;
                            state_next      = S_REPLY;
                        end
                        else
                        begin
                            // Move entries above the target down by one.
                            issue_idx_next  = AW'(pos_reg) + AW'(1);
                            issue_left_next = count_reg - CW'(pos_reg) - CW'(1);
                            state_next      = S_SCAN;
                        end
                    end
                    OP_APPEND:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            rep_status_next = ST_FULL;
                            state_next      = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    OP_SEARCH, OP_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            rep_status_next = ST_EMPTY;
                            state_next      = S_REPLY;
                        end
                        else
                        begin
                            issue_idx_next  = '0;
                            issue_left_next = count_reg;
                            state_next      = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // Unused operation codes are dropped silently.
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    // Issue the next read of the walk.
                    if (issue_left_reg != '0)
                    begin
                        mem_rd_en       = 1'b1;
                        rd_pend_next    = 1'b1;
                        rd_idx_next     = issue_idx_reg;
                        issue_left_next = issue_left_reg - CW'(1);
                        if (op_reg == OP_INSERT)
                        begin
                            issue_idx_next = issue_idx_reg - AW'(1);
                        end
                        else
                        begin
                            issue_idx_next = issue_idx_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                    end

                    // Act on the word from the last read issued.
                    if (rd_pend_reg)
                    begin
                        case (op_reg)
                            OP_INSERT:
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = rd_idx_reg + AW'(1);
                            end
                            OP_DELETE:
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = rd_idx_reg - AW'(1);
                            end
                            OP_SEARCH:
                            begin
                                // Hold back each match until the next one or
                                // the end of the walk shows whether it is last.
                                if (is_match)
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        emit                   = 1'b1;
                                        emit_word.status       = ST_MATCH;
                                        emit_word.result_index = RIDX_W'(pend_idx_reg);
                                        emit_word.result_value = pend_val_reg;
                                        emit_word.fill_level   = FILL_W'(count_reg);
                                        emit_word.last         = 1'b0;
                                    end
                                    pend_valid_next = 1'b1;
                                    pend_idx_next   = rd_idx_reg;
                                    pend_val_next   = mem_rd_data;
                                end
                            end
                            OP_READ:
                            begin
                                emit                   = 1'b1;
                                emit_word.status       = ST_ELEMENT;
                                emit_word.result_index = RIDX_W'(rd_idx_reg);
                                emit_word.result_value = mem_rd_data;
                                emit_word.fill_level   = FILL_W'(count_reg);
                                emit_word.last         =
                                    ((CW'(rd_idx_reg) + CW'(1)) == count_reg);
                            end
                            default:
                            begin
                                emit = 1'b0;
                            end
                        endcase
                    end
                end

                if ((issue_left_reg == '0) && !rd_pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                case (op_reg)
                    OP_INSERT, OP_APPEND:
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = (op_reg == OP_APPEND) ? AW'(count_reg) : AW'(pos_reg);
                        mem_wr_data = val_reg;
                        count_next      = count_reg + CW'(1);
                        rep_status_next = ST_DONE;
                        state_next      = S_REPLY;
                    end
                    OP_DELETE:
                    begin
                        count_next      = count_reg - CW'(1);
                        rep_status_next = ST_DONE;
                        state_next      = S_REPLY;
                    end
                    OP_SEARCH:
                    begin
                        if (pend_valid_reg)
                        begin
                            if (can_emit)
                            begin
                                emit                   = 1'b1;
                                emit_word.status       = ST_MATCH;
                                emit_word.result_index = RIDX_W'(pend_idx_reg);
                                emit_word.result_value = pend_val_reg;
                                emit_word.fill_level   = FILL_W'(count_reg);
                                emit_word.last         = 1'b1;
                                pend_valid_next        = 1'b0;
                                state_next             = S_IDLE;
                            end
                        end
                        else
                        begin
                            rep_status_next = ST_NOTFOUND;
                            state_next      = S_REPLY;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_REPLY:
            begin
                // Single status word closing the command.
                if (can_emit)
                begin
                    emit             = 1'b1;
                    emit_word.status = rep_status_reg;
                    if ((rep_status_reg == ST_DONE) && (count_reg != '0))
                    begin
                        emit_word.result_index = RIDX_W'(count_reg - CW'(1));
                    end
                    emit_word.fill_level = FILL_W'(count_reg);
                    emit_word.last       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output slot: drains on handshake, refills on emit.
        out_valid_next = out_valid_reg && !rsp.ready;
        out_word_next  = out_word_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            pos_reg        <= '0;
            val_reg        <= '0;
            count_reg      <= '0;
            issue_idx_reg  <= '0;
            issue_left_reg <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            pend_val_reg   <= '0;
            rep_status_reg <= ST_DONE;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            pos_reg        <= pos_next;
            val_reg        <= val_next;
            count_reg      <= count_next;
            issue_idx_reg  <= issue_idx_next;
            issue_left_reg <= issue_left_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            pend_val_reg   <= pend_val_next;
            rep_status_reg <= rep_status_next;
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
        end
    end

    assign cmd.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_word_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // Only commands that change the table write the memory.
    a_write_op: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> ((op_reg == OP_INSERT) || (op_reg == OP_DELETE) ||
                       (op_reg == OP_APPEND)))
        else $error("memory write during a read-only command");

    // The fill count is steady while the memory is being walked.
    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(count_reg))
        else $error("fill count changed during a walk");

    // A read-out word held back by a full output slot is not lost.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && rd_pend_reg && (op_reg == OP_READ) &&
         out_valid_reg && !rsp.ready)
        |=> (rd_pend_reg && $stable(rd_idx_reg)))
        else $error("pending read data dropped during a stall");

endmodule

// File: rtl/ordered_array_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table
// Packed table of up to CAPACITY signed 32-bit entries with insert, delete,
// append, search and read-out commands.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word       | Notes
//  cmd     | in        | cmd_word_t | one command per word
//  rsp     | out       | rsp_word_t | one or more result words per known command,
//          |           |            | last set on the final one
//
//  A command is taken and decoded, the entries it moves or reads are walked,
//  and a finishing step updates the fill count, writes the new entry (insert,
//  append) or emits the last match (search); a status word then closes it,
//  except after a read-out or a search with matches. Append skips the walk;
//  errors go from decoding straight to the status word.
//  Reset clears the fill count at once; the entry memory needs no clearing.
//  A full output slot stalls the walk; no new command is taken until the
//  previous one has placed its last word in the slot.
// ----------------------------------------------------------------------------
module ordered_array_table_top #(
    parameter int CAPACITY = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    oat_stream_if.sink   cmd,
    oat_stream_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [31:0]   mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]   mem_rd_data;

    // Command sequencer and output slot.
    oat_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Entry storage.
    oat_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
